// ===== rtl/sbd_pkg.sv =====
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants and controller/datapath interface types for the signed
// binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int VALUE_W   = 32;
    localparam int CHAR_W    = 8;
    localparam int DIGITS    = 10;
    localparam int IDX_W     = 4;
    localparam int DEC_RADIX = 10;
    // Wide enough for nine times the largest power of ten.
    localparam int WIDE_W    = VALUE_W + 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    localparam logic [WIDE_W-1:0] POW10 [DIGITS] = '{
        34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
        34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
    };

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic push;
    } sbd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
        logic final_char;
    } sbd_sts_t;

endpackage

// ===== rtl/sbd_datapath.sv =====
// ----------------------------------------------------------------------------
// sbd_datapath
// Magnitude register, digit extraction by compare and subtract against the
// multiples of each power of ten, digit pointer and the output register of
// the character channel.
// ----------------------------------------------------------------------------
module sbd_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [sbd_pkg::VALUE_W-1:0]   s_value,
    input  sbd_pkg::sbd_cmd_t             cmd,
    output sbd_pkg::sbd_sts_t             sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbd_pkg::CHAR_W-1:0]    m_character,
    output logic                          m_last_char
);
    import sbd_pkg::*;

    logic [VALUE_W-1:0]          mag_reg;
    logic [WIDE_W-1:0]           mag_wide;
    logic [WIDE_W-1:0]           weight [1:DEC_RADIX-1];
    logic [WIDE_W-1:0]           sub_val;
    logic [3:0]                  digit;
    logic                        neg_reg;
    logic                        sign_pend_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            top_idx;
    logic                        m_valid_reg;
    logic [CHAR_W-1:0]           m_character_reg;
    logic                        m_last_char_reg;
    logic [CHAR_W-1:0]           next_char;

    assign mag_wide = WIDE_W'(mag_reg);

    // Multiples of the weight of the digit under the pointer.
    always_comb begin
        for (int d = 1; d < DEC_RADIX; d++) begin
            weight[d] = '0;
            for (int k = 0; k < DIGITS; k++) begin
                if (idx_reg == IDX_W'(k)) begin
                    weight[d] = WIDE_W'(d) * POW10[k];
                end
            end
        end
    end

    // The largest multiple that still fits gives the digit.
    always_comb begin
        digit   = '0;
        sub_val = '0;
        for (int d = 1; d < DEC_RADIX; d++) begin
            if (mag_wide >= weight[d]) begin
                digit   = 4'(d);
                sub_val = weight[d];
            end
        end
    end

    // Highest digit position in use; zero keeps a single digit.
    always_comb begin
        top_idx = '0;
        for (int k = 1; k < DIGITS; k++) begin
            if (mag_wide >= POW10[k]) begin
                top_idx = IDX_W'(k);
            end
        end
    end

    assign next_char = sign_pend_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digit});

    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.final_char = !sign_pend_reg && (idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mag_reg <= s_value[VALUE_W-1] ? (~s_value + 1'b1) : s_value;
            neg_reg <= s_value[VALUE_W-1];
        end else if (cmd.push && !sign_pend_reg) begin
            mag_reg <= mag_reg - sub_val[VALUE_W-1:0];
        end
        if (cmd.prep) begin
            idx_reg       <= top_idx;
            sign_pend_reg <= neg_reg;
        end else if (cmd.push) begin
            if (sign_pend_reg) begin
                sign_pend_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
        if (cmd.push) begin
            m_character_reg <= next_char;
            m_last_char_reg <= sts.final_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last_char = m_last_char_reg;

`ifndef ASSERT_OFF
    a_push_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_ready))
        else $error("character pushed over a word not yet taken");
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_character_reg == CHAR_MINUS) |-> !m_last_char_reg)
        else $error("minus sign flagged as last character");
    a_final_exhausts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && sts.final_char) |-> (mag_wide == sub_val))
        else $error("magnitude left over after the last character");
`endif

endmodule

// ===== rtl/sbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbd_ctrl
// Sequencer: accepts a word, sets up the digit pointer and pushes one
// character per free output slot.
// ----------------------------------------------------------------------------
module sbd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output sbd_pkg::sbd_cmd_t cmd,
    input  sbd_pkg::sbd_sts_t sts
);
    import sbd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.push = 1'b1;
                    if (sts.final_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/signed_binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// Converts a signed 32-bit word into its decimal ASCII text, one character
// per output word, most significant first, with a leading minus if negative.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  input   | s_valid, s_ready, s_value[31:0]    | in
//  output  | m_valid, m_ready, m_character[7:0],| out
//          | m_last_char                        |
//
// A word of 1 to 11 characters passes through an accept state, a setup state
// that finds the digit count, then one character per cycle while the output
// is not stalled, each digit from a compare and subtract.
// aresetn is synchronous and clears the sequencer and the output valid.
// m_ready low holds the current character; s_ready is high only while idle,
// and the next word is taken even while the last character still waits.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbd_pkg::VALUE_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbd_pkg::CHAR_W-1:0]    m_character,
    output logic                          m_last_char
);
    import sbd_pkg::*;

    sbd_cmd_t cmd;
    sbd_sts_t sts;

    sbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    sbd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last_char (m_last_char)
    );

endmodule
